[sv/dzrq_pkg.sv]
// Shared types and constants of the dead-zone residual quantizer.
`timescale 1ns / 1ps

package dzrq_pkg;

   // Default pixel width of the top level.
   localparam int PIXEL_BITS_DEFAULT = 16;

   // Quotient bits produced by the divider, one per stage.
   localparam int QUOT_BITS = 15;

   // Largest code and dequantized magnitude.
   localparam logic [15:0] MAG_MAX = 16'd32767;

   // Most negative 16-bit code.
   localparam logic [15:0] CODE_MIN = 16'h8000;

   // Configuration register indexes.
   localparam logic [1:0] CSR_DEAD_ZONE  = 2'd0;
   localparam logic [1:0] CSR_QUANT_STEP = 2'd1;
   localparam logic [1:0] CSR_FRAC_BITS  = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [15:0] DEAD_ZONE_RESET  = 16'd0;
   localparam logic [15:0] QUANT_STEP_RESET = 16'd256;
   localparam logic [4:0]  FRAC_BITS_RESET  = 5'd8;

   // One item as it moves down the pipeline.
   typedef struct packed {
      logic                 action;
      logic                 eof;
      logic [15:0]          prev;
      logic [15:0]          code;
      logic [15:0]          res;
      logic                 neg;
      logic                 sat;
      logic [15:0]          mag;
      logic [31:0]          rem;
      logic [QUOT_BITS-1:0] quot;
      logic [30:0]          prod;
      logic [15:0]          rr;
   } item_type;

endpackage

[sv/dzrq_div_stage.sv]
// One stage of the restoring divider: resolves one quotient bit of an item.
`timescale 1ns / 1ps

module dzrq_div_stage #(
   parameter int BIT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        step,
   input  logic               in_valid,
   input  dzrq_pkg::item_type in_item,
   output logic               in_ready,
   output logic               out_valid,
   output dzrq_pkg::item_type out_item,
   input  logic               out_ready
);

   logic               valid_ff;
   dzrq_pkg::item_type item_ff;
   dzrq_pkg::item_type item_in;
   logic [31:0]        divisor;

   // The stage takes a new item when it is empty or its item moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Compare the remainder with the shifted step and subtract on success.
   assign divisor = 32'(step) << BIT;

   always_comb begin
      item_in = in_item;
      if (in_item.rem >= divisor) begin
         item_in.rem       = in_item.rem - divisor;
         item_in.quot[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

[sv/dead_zone_residual_quantizer.sv]
// Top level of the temporal residual coder with a dead-zone quantizer.
// Throughput: one item per cycle while rsp_stall is low; the 15-stage
// restoring divider resolves one quotient bit per stage, so every stage can hold a different item.
// A stalled output holds its stage; empty stages upstream still fill.
// Reset empties the pipeline and loads the register defaults.
`timescale 1ns / 1ps

module dead_zone_residual_quantizer #(
   parameter int PIXEL_BITS = dzrq_pkg::PIXEL_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [15:0] req_current_pixel,
   input  logic [15:0] req_previous_pixel,
   input  logic [15:0] req_code_in,
   input  logic        req_end_of_frame,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_residual,
   output logic [15:0] rsp_code,
   output logic [15:0] rsp_recon_residual,
   output logic [15:0] rsp_recon_pixel,
   output logic        rsp_saturated,
   output logic        rsp_frame_end
);

   localparam int          QB       = dzrq_pkg::QUOT_BITS;
   localparam logic [15:0] PIX_MASK = 16'((32'd1 << PIXEL_BITS) - 32'd1);

   // Configuration registers.
   logic [15:0] dead_zone_ff;
   logic [15:0] quant_step_ff;
   logic [4:0]  frac_bits_ff;
   logic [15:0] step_eff;
   logic [4:0]  frac_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff  <= dzrq_pkg::DEAD_ZONE_RESET;
         quant_step_ff <= dzrq_pkg::QUANT_STEP_RESET;
         frac_bits_ff  <= dzrq_pkg::FRAC_BITS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            dzrq_pkg::CSR_DEAD_ZONE:  dead_zone_ff  <= csr_data;
            dzrq_pkg::CSR_QUANT_STEP: quant_step_ff <= csr_data;
            dzrq_pkg::CSR_FRAC_BITS:  frac_bits_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // A zero step acts as one; the fraction count is limited to 1..16.
   always_comb begin
      step_eff = (quant_step_ff == 16'd0) ? 16'd1 : quant_step_ff;
      if (frac_bits_ff < 5'd1) begin
         frac_eff = 5'd1;
      end else if (frac_bits_ff > 5'd16) begin
         frac_eff = 5'd16;
      end else begin
         frac_eff = frac_bits_ff;
      end
   end

   // Pipeline registers and the ready chain, from the output back.
   logic               a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   dzrq_pkg::item_type a_item_ff, b_item_ff, c_item_ff, d_item_ff, e_item_ff;
   dzrq_pkg::item_type a_item_in, b_item_in, c_item_in, d_item_in, e_item_in;
   logic               a_rdy, b_rdy, c_rdy, d_rdy, e_rdy, f_rdy;
   logic               rsp_valid_ff;

   logic               div_valid [0:QB];
   dzrq_pkg::item_type div_item  [0:QB];
   logic               div_rdy   [0:QB];

   assign f_rdy = !rsp_valid_ff || !rsp_stall;
   assign e_rdy = !e_valid_ff || f_rdy;
   assign d_rdy = !d_valid_ff || e_rdy;
   assign c_rdy = !c_valid_ff || div_rdy[0];
   assign b_rdy = !b_valid_ff || c_rdy;
   assign a_rdy = !a_valid_ff || b_rdy;

   assign req_stall = !a_rdy;

   // Stage A: mask the pixels and form the wrapped residual.
   logic [15:0] cur_m;
   logic [15:0] prev_m;

   always_comb begin
      cur_m            = req_current_pixel & PIX_MASK;
      prev_m           = req_previous_pixel & PIX_MASK;
      a_item_in        = '0;
      a_item_in.action = req_action;
      a_item_in.eof    = req_end_of_frame;
      a_item_in.prev   = prev_m;
      a_item_in.code   = req_code_in;
      a_item_in.res    = req_action ? 16'd0 : 16'(cur_m - prev_m);
   end

   // Stage B: magnitude after the dead zone, or the limited decode magnitude.
   logic [15:0] abs_res;

   always_comb begin
      b_item_in = a_item_ff;
      abs_res   = a_item_ff.res[15] ? 16'(-a_item_ff.res) : a_item_ff.res;
      if (!a_item_ff.action) begin
         b_item_in.neg = a_item_ff.res[15];
         b_item_in.mag = (abs_res > dead_zone_ff) ? 16'(abs_res - dead_zone_ff) : 16'd0;
      end else begin
         b_item_in.neg = a_item_ff.code[15];
         if (a_item_ff.code == dzrq_pkg::CODE_MIN) begin
            b_item_in.mag = dzrq_pkg::MAG_MAX;
            b_item_in.sat = 1'b1;
         end else begin
            b_item_in.mag = a_item_ff.code[15] ? 16'(-a_item_ff.code) : a_item_ff.code;
         end
      end
   end

   // Stage C: scaled and rounded numerator, with the code overflow test.
   logic [31:0] numer;

   always_comb begin
      c_item_in = b_item_ff;
      numer     = (32'(b_item_ff.mag) << frac_eff) + (32'd1 << (frac_eff - 5'd1));
      if (!b_item_ff.action) begin
         c_item_in.rem  = numer;
         c_item_in.quot = '0;
         c_item_in.sat  = numer >= (32'(step_eff) << QB);
      end
   end

   // Divider: one quotient bit per stage, most significant first.
   assign div_valid[0] = c_valid_ff;
   assign div_item[0]  = c_item_ff;
   assign div_rdy[QB]  = d_rdy;

   for (genvar i = 0; i < QB; i++) begin : g_div
      dzrq_div_stage #(
         .BIT (QB - 1 - i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .step      (step_eff),
         .in_valid  (div_valid[i]),
         .in_item   (div_item[i]),
         .in_ready  (div_rdy[i]),
         .out_valid (div_valid[i+1]),
         .out_item  (div_item[i+1]),
         .out_ready (div_rdy[i+1])
      );
   end

   // Stage D: limit the code magnitude and multiply it by the step.
   logic [15:0] mag_d;

   always_comb begin
      d_item_in = div_item[QB];
      mag_d     = div_item[QB].mag;
      if (!div_item[QB].action) begin
         mag_d = div_item[QB].sat ? dzrq_pkg::MAG_MAX : 16'(div_item[QB].quot);
         d_item_in.mag  = mag_d;
         d_item_in.code = div_item[QB].neg ? 16'(-mag_d) : mag_d;
      end
      d_item_in.prod = 31'(32'(mag_d) * 32'(step_eff));
   end

   // Stage E: drop the fraction, add half the dead zone, limit and sign.
   logic [31:0] recon_mag;
   logic [15:0] rmag;

   always_comb begin
      e_item_in = d_item_ff;
      recon_mag = (32'(d_item_ff.prod) >> frac_eff) + 32'(dead_zone_ff >> 1);
      rmag      = 16'd0;
      if (d_item_ff.mag != 16'd0) begin
         if (recon_mag > 32'(dzrq_pkg::MAG_MAX)) begin
            rmag          = dzrq_pkg::MAG_MAX;
            e_item_in.sat = 1'b1;
         end else begin
            rmag = recon_mag[15:0];
         end
      end
      e_item_in.rr = d_item_ff.neg ? 16'(-rmag) : rmag;
   end

   // Stage F: add the previous pixel and clamp into the pixel range.
   logic signed [17:0] pix_sum;
   logic [15:0]        pix_in;

   always_comb begin
      pix_sum = $signed({2'b00, e_item_ff.prev}) + $signed({{2{e_item_ff.rr[15]}}, e_item_ff.rr});
      if (pix_sum < 18'sd0) begin
         pix_in = 16'd0;
      end else if (pix_sum > $signed({2'b00, PIX_MASK})) begin
         pix_in = PIX_MASK;
      end else begin
         pix_in = pix_sum[15:0];
      end
   end

   // Valid bits of the stages in the top level.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_rdy) a_valid_ff <= req_valid;
         if (b_rdy) b_valid_ff <= a_valid_ff;
         if (c_rdy) c_valid_ff <= b_valid_ff;
         if (d_rdy) d_valid_ff <= div_valid[QB];
         if (e_rdy) e_valid_ff <= d_valid_ff;
         if (f_rdy) rsp_valid_ff <= e_valid_ff;
      end
   end

   // Payload of the stages and the output register.
   always_ff @(posedge clock) begin
      if (a_rdy) a_item_ff <= a_item_in;
      if (b_rdy) b_item_ff <= b_item_in;
      if (c_rdy) c_item_ff <= c_item_in;
      if (d_rdy) d_item_ff <= d_item_in;
      if (e_rdy) e_item_ff <= e_item_in;
      if (f_rdy) begin
         rsp_residual       <= e_item_ff.res;
         rsp_code           <= e_item_ff.code;
         rsp_recon_residual <= e_item_ff.rr;
         rsp_recon_pixel    <= pix_in;
         rsp_saturated      <= e_item_ff.sat;
         rsp_frame_end      <= e_item_ff.eof;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/dzrq_checker.sv]
// Port-level assertions of the quantizer and their bind to the top level.
`timescale 1ns / 1ps

module dzrq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_code,
   input logic [15:0] rsp_recon_residual,
   input logic [15:0] rsp_recon_pixel
);

   // Reset empties the output.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result stays and holds its pixel.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_recon_pixel))
      else $error("stalled result changed");

   // A zero code reconstructs to a zero residual.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code == 16'd0 |-> rsp_recon_residual == 16'd0)
      else $error("zero code with nonzero reconstruction");

   // The reconstructed residual never takes the most negative value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_recon_residual != 16'h8000)
      else $error("reconstruction magnitude not limited");

   // A negative code never reconstructs to a positive residual.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_code[15] |-> $signed(rsp_recon_residual) <= 16'sd0)
      else $error("reconstruction sign differs from code sign");

endmodule

bind dead_zone_residual_quantizer dzrq_checker u_dzrq_checker (.*);

[verif/dead_zone_residual_quantizer_test.sv]
// Self-checking testbench for the dead-zone residual quantizer: directed pixels, then random runs.
`timescale 1ns / 1ps

module dead_zone_residual_quantizer_test;

   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 5;
   localparam int TIMEOUT_NS = 2_000_000;
   // Extra wait after the last expected result has come back.
   localparam int DRAIN_CYCLES = 30;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int MAG_LIMIT = int'(dzrq_pkg::MAG_MAX);
   localparam int PIXEL_MAX = (1 << dzrq_pkg::PIXEL_BITS_DEFAULT) - 1;

   // Operation codes of the action field and the index that no register answers to.
   localparam logic ACT_ENCODE = 1'b0;
   localparam logic ACT_DECODE = 1'b1;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic        action;
      logic [15:0] current_pixel;
      logic [15:0] previous_pixel;
      logic [15:0] code_in;
      logic        end_of_frame;
   } pixel_req_type;

   typedef struct packed {
      logic [15:0] residual;
      logic [15:0] code;
      logic [15:0] recon_residual;
      logic [15:0] recon_pixel;
      logic        saturated;
      logic        frame_end;
   } pixel_rsp_type;

   typedef struct packed {
      logic [15:0] dead_zone;
      logic [15:0] quant_step;
      logic [15:0] frac_data;
   } quant_setting_type;

   typedef struct packed {
      logic [1:0]    cfg_sel;
      pixel_req_type pixel;
      logic          typed;
      pixel_rsp_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [15:0] req_current_pixel;
   logic [15:0] req_previous_pixel;
   logic [15:0] req_code_in;
   logic        req_end_of_frame;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_residual;
   logic [15:0] rsp_code;
   logic [15:0] rsp_recon_residual;
   logic [15:0] rsp_recon_pixel;
   logic        rsp_saturated;
   logic        rsp_frame_end;

   // Register contents as the block should hold them.
   logic [15:0] cfg_dead_zone = dzrq_pkg::DEAD_ZONE_RESET;
   logic [15:0] cfg_quant_step = dzrq_pkg::QUANT_STEP_RESET;
   logic [4:0]  cfg_frac_bits = dzrq_pkg::FRAC_BITS_RESET;

   pixel_rsp_type     expected_pixels[$];
   pixel_rsp_type     oldest_pixel;
   stim_row_type      directed_rows [0:20];
   quant_setting_type directed_cfg [0:3];
   int                errors = 0;
   bit                calm = 1'b0;

   dead_zone_residual_quantizer dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_current_pixel  (req_current_pixel),
      .req_previous_pixel (req_previous_pixel),
      .req_code_in        (req_code_in),
      .req_end_of_frame   (req_end_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_residual       (rsp_residual),
      .rsp_code           (rsp_code),
      .rsp_recon_residual (rsp_recon_residual),
      .rsp_recon_pixel    (rsp_recon_pixel),
      .rsp_saturated      (rsp_saturated),
      .rsp_frame_end      (rsp_frame_end)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Encode or decode one pixel against the current register contents.
   function automatic pixel_rsp_type quantize_pixel(input pixel_req_type p);
      pixel_rsp_type r;
      logic [15:0]   diff;
      int            frac, step, dz, value, mag, level, pix;
      longint        q;
      bit            neg;
      r = '0;
      r.frame_end = p.end_of_frame;
      dz = int'(cfg_dead_zone);
      frac = (cfg_frac_bits == 5'd0) ? 1 : ((cfg_frac_bits > 5'd16) ? 16 : int'(cfg_frac_bits));
      step = (cfg_quant_step == 16'd0) ? 1 : int'(cfg_quant_step);
      if (p.action == ACT_ENCODE) begin
         diff = p.current_pixel - p.previous_pixel;
         r.residual = diff;
         value = int'($signed(diff));
         neg = value < 0;
         mag = neg ? -value : value;
         mag = (mag > dz) ? mag - dz : 0;
         q = ((longint'(mag) << frac) + (longint'(1) << (frac - 1))) / step;
         if (q > MAG_LIMIT) begin
            q = MAG_LIMIT;
            r.saturated = 1'b1;
         end
         mag = int'(q);
         r.code = 16'(neg ? -mag : mag);
      end else begin
         r.code = p.code_in;
         value = int'($signed(p.code_in));
         neg = value < 0;
         mag = neg ? -value : value;
         if (mag > MAG_LIMIT) begin
            mag = MAG_LIMIT;
            r.saturated = 1'b1;
         end
      end

      // A zero code reconstructs to zero; otherwise scale back and add half the dead zone.
      level = 0;
      if (mag != 0) begin
         q = ((longint'(mag) * step) >> frac) + (dz >> 1);
         if (q > MAG_LIMIT) begin
            q = MAG_LIMIT;
            r.saturated = 1'b1;
         end
         level = neg ? -int'(q) : int'(q);
      end
      r.recon_residual = 16'(level);
      pix = int'(p.previous_pixel) + level;
      if (pix < 0) pix = 0;
      if (pix > PIXEL_MAX) pix = PIXEL_MAX;
      r.recon_pixel = 16'(pix);
      return r;
   endfunction

   function automatic int draw_wait();
      return calm ? 0 : int'($urandom_range(0, 13));
   endfunction

   // Mostly step sizes near one unit of the fixed-point format, with the extremes mixed in.
   function automatic quant_setting_type random_setting();
      quant_setting_type s;
      int                frac, scale, level;
      case ($urandom_range(0, 9))
         0: frac = 0;
         1: frac = int'($urandom_range(17, 31));
         2: frac = 16;
         default: frac = int'($urandom_range(1, 16));
      endcase
      s.frac_data = 16'(frac);
      if ($urandom_range(0, 3) == 0) s.frac_data[15:5] = 11'($urandom);
      scale = (frac < 1) ? 1 : ((frac > 16) ? 16 : frac);
      case ($urandom_range(0, 9))
         0: s.quant_step = 16'd0;
         1: s.quant_step = 16'hFFFF;
         2: s.quant_step = 16'($urandom);
         default: begin
            level = ((1 << scale) * int'($urandom_range(2, 96))) >> 4;
            s.quant_step = (level > 65535) ? 16'hFFFF : ((level < 1) ? 16'd1 : 16'(level));
         end
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: s.dead_zone = 16'($urandom_range(0, 63));
         4: s.dead_zone = 16'd0;
         5: s.dead_zone = 16'hFFFF;
         6, 7: s.dead_zone = 16'($urandom);
         default: s.dead_zone = 16'($urandom_range(64, 1024));
      endcase
      return s;
   endfunction

   // Residuals cluster around the dead zone; codes cluster near zero, with extremes.
   function automatic pixel_req_type random_pixel();
      pixel_req_type p;
      int            spread, delta;
      p.action = 1'($urandom_range(0, 1));
      p.end_of_frame = ($urandom_range(0, 15) == 0);
      case ($urandom_range(0, 15))
         0: p.previous_pixel = 16'h0000;
         1: p.previous_pixel = 16'hFFFF;
         default: p.previous_pixel = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0, 1: p.current_pixel = 16'($urandom);
         2: p.current_pixel = p.previous_pixel ^ 16'h8000;
         default: begin
            spread = int'(cfg_dead_zone) + int'($urandom_range(16, 4096));
            delta = int'($urandom_range(0, 2 * spread)) - spread;
            p.current_pixel = 16'(int'(p.previous_pixel) + delta);
         end
      endcase
      case ($urandom_range(0, 7))
         0, 1: p.code_in = 16'($urandom);
         2: begin
            case ($urandom_range(0, 5))
               0: p.code_in = dzrq_pkg::CODE_MIN;
               1: p.code_in = dzrq_pkg::MAG_MAX;
               2: p.code_in = 16'h0000;
               3: p.code_in = 16'hFFFF;
               4: p.code_in = 16'h8001;
               default: p.code_in = 16'h0001;
            endcase
         end
         default: p.code_in = 16'($urandom_range(0, 1024) - 512);
      endcase
      return p;
   endfunction

   // Compare one field of a result.
   task automatic check_field(input string label, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s expected %h, got %h", $time, label, want, got);
      end
   endtask

   // Present one item, hold it until accepted, then queue its expected result.
   task automatic send_pixel(input pixel_req_type p, input pixel_rsp_type want);
      int n;
      n = draw_wait();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= p.action;
      req_current_pixel <= p.current_pixel;
      req_previous_pixel <= p.previous_pixel;
      req_code_in <= p.code_in;
      req_end_of_frame <= p.end_of_frame;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_pixels.push_back(want);
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic settle_pipeline();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      @(posedge clock);
      case (index)
         dzrq_pkg::CSR_DEAD_ZONE:  cfg_dead_zone = data;
         dzrq_pkg::CSR_QUANT_STEP: cfg_quant_step = data;
         dzrq_pkg::CSR_FRAC_BITS:  cfg_frac_bits = data[4:0];
         default: ;
      endcase
   endtask

   // Load a full setting; the write to the unused index must change nothing.
   task automatic program_quantizer(input quant_setting_type s);
      write_reg(dzrq_pkg::CSR_DEAD_ZONE, s.dead_zone);
      write_reg(dzrq_pkg::CSR_QUANT_STEP, s.quant_step);
      write_reg(dzrq_pkg::CSR_FRAC_BITS, s.frac_data);
      write_reg(CSR_UNUSED, 16'($urandom));
      csr_write <= 1'b0;
   endtask

   // Result side: a random stall before each item, then take it.
   initial begin
      int n;
      rsp_stall <= 1'b0;
      forever begin
         n = draw_wait();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset !== 1'b0);
      end
   end

   // Check every accepted result against the oldest expectation.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected item, got code %h pixel %h",
                     $time, rsp_code, rsp_recon_pixel);
         end else begin
            oldest_pixel = expected_pixels.pop_front();
            check_field("residual", oldest_pixel.residual, rsp_residual);
            check_field("code", oldest_pixel.code, rsp_code);
            check_field("recon_residual", oldest_pixel.recon_residual, rsp_recon_residual);
            check_field("recon_pixel", oldest_pixel.recon_pixel, rsp_recon_pixel);
            check_field("saturated", 16'(oldest_pixel.saturated), 16'(rsp_saturated));
            check_field("frame_end", 16'(oldest_pixel.frame_end), 16'(rsp_frame_end));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("dead_zone_residual_quantizer_test: errors");
      $finish;
   end

   initial begin
      stim_row_type row;
      int           active_sel;
      int           phase;

      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= dzrq_pkg::CSR_DEAD_ZONE;
      csr_data <= 16'h0000;
      req_valid <= 1'b0;
      req_action <= ACT_ENCODE;
      req_current_pixel <= 16'h0000;
      req_previous_pixel <= 16'h0000;
      req_code_in <= 16'h0000;
      req_end_of_frame <= 1'b0;

      // Reset values, then zero step with too few fraction bits,
      // everything at its maximum, and the finest step.
      directed_cfg[0] = '{dzrq_pkg::DEAD_ZONE_RESET, dzrq_pkg::QUANT_STEP_RESET,
                          16'(dzrq_pkg::FRAC_BITS_RESET)};
      directed_cfg[1] = '{16'd20, 16'd0, 16'd0};
      directed_cfg[2] = '{16'hFFFF, 16'hFFFF, 16'd31};
      directed_cfg[3] = '{16'd0, 16'd1, 16'd16};

      // At reset the step is one whole unit, so a code equals its residual unless it saturates.
      directed_rows = '{
         '{2'd0, '{ACT_ENCODE, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
           '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0}},
         '{2'd0, '{ACT_ENCODE, 16'hFFFF, 16'h0000, 16'h0000, 1'b1}, 1'b1,
           '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b1}},
         '{2'd0, '{ACT_ENCODE, 16'h0000, 16'hFFFF, 16'h7FFF, 1'b0}, 1'b1,
           '{16'h0001, 16'h0001, 16'h0001, 16'hFFFF, 1'b0, 1'b0}},
         '{2'd0, '{ACT_ENCODE, 16'h8000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
           '{dzrq_pkg::CODE_MIN, 16'h8001, 16'h8001, 16'h0000, 1'b1, 1'b0}},
         '{2'd0, '{ACT_ENCODE, 16'h9C40, 16'h2710, 16'h8000, 1'b0}, 1'b1,
           '{16'h7530, 16'h7530, 16'h7530, 16'h9C40, 1'b0, 1'b0}},
         '{2'd0, '{ACT_DECODE, 16'h1234, 16'h9C40, dzrq_pkg::CODE_MIN, 1'b0}, 1'b1,
           '{16'h0000, dzrq_pkg::CODE_MIN, 16'h8001, 16'h1C41, 1'b1, 1'b0}},
         '{2'd0, '{ACT_DECODE, 16'hFFFF, 16'hFFFF, dzrq_pkg::MAG_MAX, 1'b1}, 1'b1,
           '{16'h0000, dzrq_pkg::MAG_MAX, dzrq_pkg::MAG_MAX, 16'hFFFF, 1'b0, 1'b1}},
         '{2'd0, '{ACT_DECODE, 16'hFFFF, 16'h04D2, 16'h0000, 1'b0}, 1'b1,
           '{16'h0000, 16'h0000, 16'h0000, 16'h04D2, 1'b0, 1'b0}},
         '{2'd0, '{ACT_DECODE, 16'h5555, 16'h0000, 16'hFFFF, 1'b0}, 1'b1,
           '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 1'b0}},
         '{2'd0, '{ACT_ENCODE, 16'h0001, 16'h0000, 16'hAAAA, 1'b1}, 1'b1,
           '{16'h0001, 16'h0001, 16'h0001, 16'h0001, 1'b0, 1'b1}},
         '{2'd1, '{ACT_ENCODE, 16'h0064, 16'h006E, 16'h0000, 1'b0}, 1'b0, '0},
         '{2'd1, '{ACT_ENCODE, 16'h0082, 16'h0064, 16'h0000, 1'b0}, 1'b0, '0},
         '{2'd1, '{ACT_ENCODE, 16'h8000, 16'h0000, 16'h0000, 1'b0}, 1'b0, '0},
         '{2'd1, '{ACT_DECODE, 16'h0000, 16'h0032, 16'h0064, 1'b0}, 1'b0, '0},
         '{2'd1, '{ACT_DECODE, 16'h0000, 16'hFFFF, dzrq_pkg::CODE_MIN, 1'b1}, 1'b0, '0},
         '{2'd2, '{ACT_ENCODE, 16'hFFFF, 16'h7FFF, 16'h0000, 1'b0}, 1'b0, '0},
         '{2'd2, '{ACT_DECODE, 16'h0000, 16'h0000, dzrq_pkg::MAG_MAX, 1'b0}, 1'b0, '0},
         '{2'd2, '{ACT_DECODE, 16'h0000, 16'h0064, 16'hFFFB, 1'b1}, 1'b0, '0},
         '{2'd3, '{ACT_ENCODE, 16'h1234, 16'h1234, 16'h0000, 1'b0}, 1'b0, '0},
         '{2'd3, '{ACT_ENCODE, 16'h0005, 16'h0000, 16'h0000, 1'b0}, 1'b0, '0},
         '{2'd3, '{ACT_DECODE, 16'h0000, 16'h03E8, 16'h0001, 1'b1}, 1'b0, '0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels; the registers change only with the pipeline empty.
      active_sel = 0;
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (int'(row.cfg_sel) != active_sel) begin
            settle_pipeline();
            program_quantizer(directed_cfg[row.cfg_sel]);
            active_sel = int'(row.cfg_sel);
         end
         send_pixel(row.pixel, row.typed ? row.want : quantize_pixel(row.pixel));
      end

      // Random runs, each under a fresh setting; every third one runs without idling.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_pipeline();
         program_quantizer(random_setting());
         calm = (phase % 3 == 2);
         repeat (ITEMS_PER_PHASE) begin
            pixel_req_type p;
            p = random_pixel();
            send_pixel(p, quantize_pixel(p));
         end
      end

      calm = 1'b0;
      settle_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("dead_zone_residual_quantizer_test: clean");
      else
         $display("dead_zone_residual_quantizer_test: errors");
      $finish;
   end

endmodule
